@@ rtl/pmd_pkg.sv @@
`default_nettype none

package pmd_pkg;

   // Fixed by the payload layout: four channels of five samples each.
   localparam int CHANNELS     = 4;
   localparam int FAST_SAMPLES = 5;

   localparam int SAMPLE_CNT_W = $clog2(FAST_SAMPLES + 1);
   localparam int MAJ_W        = 3;
   localparam int DEB_W        = 4;
   localparam int TIME_W       = 32;
   localparam int CMP_W        = (SAMPLE_CNT_W > MAJ_W) ? SAMPLE_CNT_W : MAJ_W;

   localparam logic [MAJ_W-1:0]  MAJORITY_RESET = MAJ_W'(3);
   localparam logic [DEB_W-1:0]  DEBOUNCE_RESET = DEB_W'(4);
   localparam logic [TIME_W-1:0] HOLD_MS_RESET  = TIME_W'(10 * 1000);

   localparam int CSR_INDEX_W = 2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MAJORITY_NEEDED = 2'd0,
      CSR_DEBOUNCE_POLLS  = 2'd1,
      CSR_ABSENT_HOLD_MS  = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [TIME_W-1:0]       now_ms;
      logic [FAST_SAMPLES-1:0] levels_ch3;
      logic [FAST_SAMPLES-1:0] levels_ch2;
      logic [FAST_SAMPLES-1:0] levels_ch1;
      logic [FAST_SAMPLES-1:0] levels_ch0;
   } req_payload_type;

   typedef struct packed {
      logic [CHANNELS-1:0] present_mask;
      logic                boot_lock;
      logic                status_valid;
   } rsp_payload_type;

   // Number of samples that read low (present).
   function automatic logic [SAMPLE_CNT_W-1:0] count_low(
      input logic [FAST_SAMPLES-1:0] levels
   );
      logic [SAMPLE_CNT_W-1:0] n;
      n = '0;
      for (int b = 0; b < FAST_SAMPLES; b++) begin
         if (!levels[b]) begin
            n = n + SAMPLE_CNT_W'(1);
         end
      end
      return n;
   endfunction

endpackage

`default_nettype wire

@@ rtl/presence_majority_debounce.sv @@
// Presence majority-vote debouncer with start-up lock.
//
// Request channel (req_valid / req_stall / req_payload): one poll per request,
// carrying five pin samples for each of four channels and a millisecond
// timestamp. A request is taken on a rising edge with req_valid high and
// req_stall low.
// Result channel (rsp_valid / rsp_stall / rsp_payload): exactly one result per
// request, in order: the confirmed presence mask, the boot lock, and the
// status-valid flag (inverse of the lock).
// Configuration (csr_valid / csr_ready / csr_index / csr_data): csr_ready is
// always high; write only while no request is in flight.
// A poll moves from the input register through the vote/debounce/lock logic
// into the result register, where rsp_valid rises. Throughput is one request
// per cycle while the receiver does not stall, set by the single pass through
// the per-channel logic that reads and updates the channel state.
// Reset (synchronous, active high) clears all channel state, holds the lock,
// disarms the absence timer and restores the register defaults (majority 3,
// debounce 4 polls, hold 10000 ms). When the receiver stalls, the result
// register holds; the input register still takes one more request, and
// req_stall rises only when both registers are full.

`default_nettype none

module presence_majority_debounce (
   input  wire                                      clock,
   input  wire                                      reset,
   input  wire                                      req_valid,
   output logic                                     req_stall,
   input  pmd_pkg::req_payload_type                 req_payload,
   output logic                                     rsp_valid,
   input  wire                                      rsp_stall,
   output pmd_pkg::rsp_payload_type                 rsp_payload,
   input  wire                                      csr_valid,
   output logic                                     csr_ready,
   input  wire  [pmd_pkg::CSR_INDEX_W-1:0]          csr_index,
   input  wire  [pmd_pkg::TIME_W-1:0]               csr_data
);

   localparam int CH = pmd_pkg::CHANNELS;

   // Configuration registers.
   logic [pmd_pkg::MAJ_W-1:0]  majority_ff;
   logic [pmd_pkg::DEB_W-1:0]  debounce_ff;
   logic [pmd_pkg::TIME_W-1:0] hold_ms_ff;

   // Pipeline registers.
   logic                     s1_valid_ff, s1_valid_in;
   pmd_pkg::req_payload_type s1_payload_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   pmd_pkg::rsp_payload_type rsp_payload_ff, rsp_payload_in;

   // Channel and lock state.
   logic [CH-1:0]             conf_ff, conf_in;
   logic [pmd_pkg::DEB_W-1:0] cnt_ff [CH];
   logic [pmd_pkg::DEB_W-1:0] cnt_in [CH];
   logic                      lock_ff, lock_in;
   logic [pmd_pkg::TIME_W-1:0] start_ff, start_in;
   logic                      armed_ff, armed_in;

   logic req_take;
   logic out_load;
   logic advance;

   logic [pmd_pkg::FAST_SAMPLES-1:0] levels [CH];
   logic [pmd_pkg::TIME_W-1:0]       elapsed;

   assign csr_ready = 1'b1;

   // The result register loads whenever it is empty or being drained; the
   // input register moves into it at the same time.
   assign out_load  = !rsp_valid_ff || !rsp_stall;
   assign advance   = s1_valid_ff && out_load;
   assign req_stall = s1_valid_ff && !out_load;
   assign req_take  = req_valid && !req_stall;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   assign levels[0] = s1_payload_ff.levels_ch0;
   assign levels[1] = s1_payload_ff.levels_ch1;
   assign levels[2] = s1_payload_ff.levels_ch2;
   assign levels[3] = s1_payload_ff.levels_ch3;

   // Wrapped elapsed time since the absence timer was armed.
   assign elapsed = s1_payload_ff.now_ms - start_ff;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Majority vote, debounce and boot-lock update for the poll in the input
   // register. State only changes when that poll moves to the result register.
   always_comb begin
      logic [pmd_pkg::DEB_W-1:0] inc;
      logic                      raw;
      logic [pmd_pkg::CMP_W-1:0] n_low;
      logic [pmd_pkg::CMP_W-1:0] need;

      conf_in  = conf_ff;
      lock_in  = lock_ff;
      start_in = start_ff;
      armed_in = armed_ff;
      for (int i = 0; i < CH; i++) begin
         cnt_in[i] = cnt_ff[i];
      end

      for (int i = 0; i < CH; i++) begin
         n_low = pmd_pkg::CMP_W'(pmd_pkg::count_low(levels[i]));
         need  = pmd_pkg::CMP_W'(majority_ff);
         raw   = (n_low >= need);
         inc   = cnt_ff[i] + pmd_pkg::DEB_W'(1);
         if (raw == conf_ff[i]) begin
            cnt_in[i] = '0;
         end else if (inc >= debounce_ff) begin
            // A zero debounce setting behaves like one: any disagreement flips.
            conf_in[i] = raw;
            cnt_in[i]  = '0;
         end else begin
            cnt_in[i] = inc;
         end
      end

      // The lock is released only after a full hold period with nothing
      // confirmed present; any presence disarms the timer again.
      if (lock_ff) begin
         if (conf_in != '0) begin
            armed_in = 1'b0;
         end else if (!armed_ff) begin
            start_in = s1_payload_ff.now_ms;
            armed_in = 1'b1;
         end else if (elapsed >= hold_ms_ff) begin
            lock_in = 1'b0;
         end
      end

      rsp_payload_in.present_mask = conf_in;
      rsp_payload_in.boot_lock    = lock_in;
      rsp_payload_in.status_valid = !lock_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         majority_ff <= pmd_pkg::MAJORITY_RESET;
         debounce_ff <= pmd_pkg::DEBOUNCE_RESET;
         hold_ms_ff  <= pmd_pkg::HOLD_MS_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            pmd_pkg::CSR_MAJORITY_NEEDED: majority_ff <= csr_data[pmd_pkg::MAJ_W-1:0];
            pmd_pkg::CSR_DEBOUNCE_POLLS:  debounce_ff <= csr_data[pmd_pkg::DEB_W-1:0];
            pmd_pkg::CSR_ABSENT_HOLD_MS:  hold_ms_ff  <= csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_payload_ff <= req_payload;
      end
      if (advance) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         conf_ff  <= '0;
         lock_ff  <= 1'b1;
         start_ff <= '0;
         armed_ff <= 1'b0;
         for (int i = 0; i < CH; i++) begin
            cnt_ff[i] <= '0;
         end
      end else if (advance) begin
         conf_ff  <= conf_in;
         lock_ff  <= lock_in;
         start_ff <= start_in;
         armed_ff <= armed_in;
         for (int i = 0; i < CH; i++) begin
            cnt_ff[i] <= cnt_in[i];
         end
      end
   end

   // Once released, the lock stays released until reset.
   a_lock_sticky: assert property (@(posedge clock) disable iff (reset)
      !lock_ff |=> !lock_ff)
      else $error("boot lock was taken again after release");

   // The lock can only be released from an armed absence timer.
   a_release_armed: assert property (@(posedge clock) disable iff (reset)
      $fell(lock_ff) |-> $past(armed_ff))
      else $error("boot lock released without an armed absence timer");

   // A disagreement counter flips its channel before it can reach its top value.
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff[0] != '1) && (cnt_ff[1] != '1) && (cnt_ff[2] != '1) && (cnt_ff[3] != '1))
      else $error("disagreement counter reached its top value");

endmodule

`default_nettype wire
